[rtl/bfa_pkg.sv]
// bfa_pkg: shared types, codes and constants of the best-fit allocator.
// No dependencies; used by every RTL file except bfa_ram and by the port checker.
`default_nettype none

package bfa_pkg;

    localparam int DEF_MAX_BLOCKS = 64;
    localparam int ADDR_BITS      = 20;
    localparam int SZ_W           = 21;
    localparam int ID_W           = 32;
    localparam logic [SZ_W-1:0] MEM_LIMIT = SZ_W'(1) << ADDR_BITS;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOID  = 2'd3;

    // Datapath commands
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NOP        = 4'd0;
    localparam t_cmd CMD_INIT       = 4'd1;
    localparam t_cmd CMD_ACCEPT     = 4'd2;
    localparam t_cmd CMD_SCAN_ALLOC = 4'd3;
    localparam t_cmd CMD_SCAN_FREE  = 4'd4;
    localparam t_cmd CMD_SCAN_STAT  = 4'd5;
    localparam t_cmd CMD_MARK_FULL  = 4'd6;
    localparam t_cmd CMD_UP_BEGIN   = 4'd7;
    localparam t_cmd CMD_UP_STEP    = 4'd8;
    localparam t_cmd CMD_WR_SPLIT   = 4'd9;
    localparam t_cmd CMD_WR_BEST    = 4'd10;
    localparam t_cmd CMD_WR_MERGE   = 4'd11;
    localparam t_cmd CMD_DN_STEP    = 4'd12;
    localparam t_cmd CMD_SHRINK     = 4'd13;
    localparam t_cmd CMD_STAT_BEGIN = 4'd14;
    localparam t_cmd CMD_FINISH     = 4'd15;

    // One table entry
    typedef struct packed {
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] size;
        logic            is_free;
        logic [ID_W-1:0] owner;
    } t_entry;

    // Datapath status back to the controller
    typedef struct packed {
        logic lt_count;   // read index below block count
        logic gt_best;    // read index above best index
        logic vld;        // read data in flight
        logic found;
        logic split;      // best block larger than request
        logic full;       // table at capacity
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/bfa_ram.sv]
// bfa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfa_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/bfa_datapath.sv]
// bfa_datapath: block table RAM, scan/shift index, best-fit search, merge and
// statistics registers, config register. Depends on bfa_pkg and bfa_ram.
`default_nettype none

module bfa_datapath #(
    parameter int MAX_BLOCKS = bfa_pkg::DEF_MAX_BLOCKS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bfa_pkg::t_cmd             i_cmd,
    output bfa_pkg::t_dp_stat              o_stat,
    input  wire logic                      i_cfg_wr,
    input  wire logic [bfa_pkg::SZ_W-1:0]  i_cfg_data,
    output logic      [bfa_pkg::SZ_W-1:0]  o_mem_size,
    input  wire logic                      i_req_type,
    input  wire logic [bfa_pkg::SZ_W-1:0]  i_req_size,
    input  wire logic [bfa_pkg::ID_W-1:0]  i_free_id,
    output logic                           o_done,
    output logic      [1:0]                o_status,
    output logic      [bfa_pkg::ID_W-1:0]  o_alloc_id,
    output logic      [bfa_pkg::SZ_W-1:0]  o_alloc_start,
    output logic      [bfa_pkg::SZ_W-1:0]  o_used_total,
    output logic      [bfa_pkg::SZ_W-1:0]  o_free_total,
    output logic      [bfa_pkg::SZ_W-1:0]  o_largest_free,
    output logic      [bfa_pkg::ID_W-1:0]  o_request_count,
    output logic      [bfa_pkg::ID_W-1:0]  o_success_count
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = $bits(bfa_pkg::t_entry);
    localparam int SW = bfa_pkg::SZ_W;
    localparam int IW = bfa_pkg::ID_W;

    // control state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_vld;
    logic [IW-1:0] r_next_id;
    logic [IW-1:0] r_req_cnt;
    logic [IW-1:0] r_ok_cnt;
    logic [SW-1:0] r_mem_size;
    logic          r_done;

    // working registers
    logic [AW-1:0]   r_didx;
    logic [AW-1:0]   r_best;
    logic            r_found;
    logic            r_fullfail;
    logic            r_is_free;
    logic [SW-1:0]   r_req_size;
    logic [IW-1:0]   r_free_id;
    logic [SW-1:0]   r_best_start;
    logic [SW-1:0]   r_best_size;
    bfa_pkg::t_entry r_prev;
    bfa_pkg::t_entry r_left;
    bfa_pkg::t_entry r_cur;
    bfa_pkg::t_entry r_right;
    logic            r_left_free;
    logic            r_right_free;
    logic [1:0]      r_k;
    logic [SW-1:0]   r_used;
    logic [SW-1:0]   r_free;
    logic [SW-1:0]   r_big;

    // result registers
    logic [1:0]    r_res_status;
    logic [IW-1:0] r_res_id;
    logic [SW-1:0] r_res_start;
    logic [SW-1:0] r_res_used;
    logic [SW-1:0] r_res_free;
    logic [SW-1:0] r_res_big;

    logic [EW-1:0]   rd_data;
    bfa_pkg::t_entry rd_e;
    logic            we;
    logic [AW-1:0]   waddr;
    bfa_pkg::t_entry wdata;
    logic [SW-1:0]   cfg_clamped;
    logic            lt_count;
    logic            gt_best;
    logic [IW-1:0]   n_next_id;
    logic [SW-1:0]   merge_sum;

    assign rd_e     = bfa_pkg::t_entry'(rd_data);
    assign lt_count = r_idx < r_count;
    assign gt_best  = r_idx > CW'(r_best);

    assign o_stat = '{
        lt_count: lt_count,
        gt_best:  gt_best,
        vld:      r_vld,
        found:    r_found,
        split:    r_best_size != r_req_size,
        full:     r_count == CW'(MAX_BLOCKS)
    };

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = SW'(1);
        end else if (i_cfg_data > bfa_pkg::MEM_LIMIT) begin
            cfg_clamped = bfa_pkg::MEM_LIMIT;
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    assign n_next_id = (r_next_id + IW'(1) == '0) ? IW'(1) : r_next_id + IW'(1);
    assign merge_sum = (r_left_free ? r_left.size : '0) + r_cur.size
                     + (r_right_free ? r_right.size : '0);

    // RAM write port; a config write reloads entry 0
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (i_cfg_wr) begin
            we            = 1'b1;
            wdata.size    = cfg_clamped;
            wdata.is_free = 1'b1;
        end else begin
            unique case (i_cmd)
                bfa_pkg::CMD_INIT: begin
                    we            = 1'b1;
                    wdata.size    = r_mem_size;
                    wdata.is_free = 1'b1;
                end
                bfa_pkg::CMD_UP_STEP: begin
                    we    = r_vld;
                    waddr = r_didx + AW'(1);
                    wdata = rd_e;
                end
                bfa_pkg::CMD_DN_STEP: begin
                    we    = r_vld;
                    waddr = r_didx - AW'(r_k);
                    wdata = rd_e;
                end
                bfa_pkg::CMD_WR_SPLIT: begin
                    we            = 1'b1;
                    waddr         = r_best + AW'(1);
                    wdata.start   = r_best_start + r_req_size;
                    wdata.size    = r_best_size - r_req_size;
                    wdata.is_free = 1'b1;
                end
                bfa_pkg::CMD_WR_BEST: begin
                    we          = 1'b1;
                    waddr       = r_best;
                    wdata.start = r_best_start;
                    wdata.size  = r_req_size;
                    wdata.owner = r_next_id;
                end
                bfa_pkg::CMD_WR_MERGE: begin
                    we            = 1'b1;
                    waddr         = r_left_free ? r_best - AW'(1) : r_best;
                    wdata.start   = r_left_free ? r_left.start : r_cur.start;
                    wdata.size    = merge_sum;
                    wdata.is_free = 1'b1;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    bfa_ram #(
        .W (EW),
        .D (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(1);
            r_idx      <= '0;
            r_vld      <= 1'b0;
            r_next_id  <= IW'(1);
            r_req_cnt  <= '0;
            r_ok_cnt   <= '0;
            r_mem_size <= bfa_pkg::MEM_LIMIT;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd == bfa_pkg::CMD_FINISH;
            if (i_cfg_wr) begin
                r_mem_size <= cfg_clamped;
                r_count    <= CW'(1);
            end
            case (i_cmd) inside
                bfa_pkg::CMD_INIT: begin
                    if (!i_cfg_wr) r_count <= CW'(1);
                end
                bfa_pkg::CMD_ACCEPT: begin
                    r_idx <= '0;
                    r_vld <= 1'b0;
                    if (!i_req_type && r_req_cnt != '1) r_req_cnt <= r_req_cnt + IW'(1);
                end
                bfa_pkg::CMD_STAT_BEGIN: begin
                    r_idx <= '0;
                    r_vld <= 1'b0;
                end
                bfa_pkg::CMD_SCAN_ALLOC, bfa_pkg::CMD_SCAN_FREE,
                bfa_pkg::CMD_SCAN_STAT, bfa_pkg::CMD_DN_STEP: begin
                    r_vld <= lt_count;
                    if (lt_count) r_idx <= r_idx + CW'(1);
                end
                bfa_pkg::CMD_UP_BEGIN: begin
                    r_idx <= r_count - CW'(1);
                    r_vld <= 1'b0;
                end
                bfa_pkg::CMD_UP_STEP: begin
                    r_vld <= gt_best;
                    if (gt_best) r_idx <= r_idx - CW'(1);
                end
                bfa_pkg::CMD_WR_SPLIT: begin
                    r_count <= r_count + CW'(1);
                end
                bfa_pkg::CMD_WR_BEST: begin
                    r_next_id <= n_next_id;
                    if (r_ok_cnt != '1) r_ok_cnt <= r_ok_cnt + IW'(1);
                end
                bfa_pkg::CMD_WR_MERGE: begin
                    r_idx <= CW'(r_best) + CW'(1) + CW'(r_right_free);
                    r_vld <= 1'b0;
                end
                bfa_pkg::CMD_SHRINK: begin
                    r_count <= r_count - CW'(r_k);
                end
                default: begin
                    r_vld <= 1'b0;
                end
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            bfa_pkg::CMD_ACCEPT: begin
                r_req_size   <= i_req_size;
                r_free_id    <= i_free_id;
                r_is_free    <= i_req_type;
                r_found      <= 1'b0;
                r_fullfail   <= 1'b0;
                r_left_free  <= 1'b0;
                r_right_free <= 1'b0;
                r_res_id     <= '0;
                r_res_start  <= '0;
            end
            bfa_pkg::CMD_SCAN_ALLOC: begin
                if (r_vld && rd_e.is_free && rd_e.size >= r_req_size
                        && (!r_found || rd_e.size < r_best_size)) begin
                    r_found      <= 1'b1;
                    r_best       <= r_didx;
                    r_best_start <= rd_e.start;
                    r_best_size  <= rd_e.size;
                end
            end
            bfa_pkg::CMD_SCAN_FREE: begin
                if (r_vld) begin
                    r_prev <= rd_e;
                    if (!r_found && !rd_e.is_free && rd_e.owner == r_free_id) begin
                        r_found     <= 1'b1;
                        r_best      <= r_didx;
                        r_cur       <= rd_e;
                        r_left      <= r_prev;
                        r_left_free <= (r_didx != '0) && r_prev.is_free;
                    end
                    if (r_found && r_didx == r_best + AW'(1)) begin
                        r_right      <= rd_e;
                        r_right_free <= rd_e.is_free;
                    end
                end
            end
            bfa_pkg::CMD_MARK_FULL: begin
                r_fullfail <= 1'b1;
            end
            bfa_pkg::CMD_WR_BEST: begin
                r_res_id    <= r_next_id;
                r_res_start <= r_best_start;
            end
            bfa_pkg::CMD_WR_MERGE: begin
                r_k <= 2'(r_left_free) + 2'(r_right_free);
            end
            bfa_pkg::CMD_STAT_BEGIN: begin
                r_used <= '0;
                r_free <= '0;
                r_big  <= '0;
            end
            bfa_pkg::CMD_SCAN_STAT: begin
                if (r_vld) begin
                    if (rd_e.is_free) begin
                        r_free <= r_free + rd_e.size;
                        if (rd_e.size > r_big) r_big <= rd_e.size;
                    end else begin
                        r_used <= r_used + rd_e.size;
                    end
                end
            end
            bfa_pkg::CMD_FINISH: begin
                r_res_used <= r_used;
                r_res_free <= r_free;
                r_res_big  <= r_big;
                if (!r_found) begin
                    r_res_status <= r_is_free ? bfa_pkg::ST_NOID : bfa_pkg::ST_NOFIT;
                end else if (r_fullfail) begin
                    r_res_status <= bfa_pkg::ST_FULL;
                end else begin
                    r_res_status <= bfa_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
        r_didx <= r_idx[AW-1:0];
    end

    assign o_mem_size      = r_mem_size;
    assign o_done          = r_done;
    assign o_status        = r_res_status;
    assign o_alloc_id      = r_res_id;
    assign o_alloc_start   = r_res_start;
    assign o_used_total    = r_res_used;
    assign o_free_total    = r_res_free;
    assign o_largest_free  = r_res_big;
    assign o_request_count = r_req_cnt;
    assign o_success_count = r_ok_cnt;

endmodule

`default_nettype wire

[rtl/bfa_ctrl.sv]
// bfa_ctrl: request sequencer for the allocator; issues datapath commands.
// Depends on bfa_pkg.
`default_nettype none

module bfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_req_type,
    input  wire bfa_pkg::t_dp_stat i_stat,
    output bfa_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);

    localparam logic [3:0] S_INIT       = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_ASCAN      = 4'd2;
    localparam logic [3:0] S_UP_BEGIN   = 4'd3;
    localparam logic [3:0] S_UP         = 4'd4;
    localparam logic [3:0] S_WR_SPLIT   = 4'd5;
    localparam logic [3:0] S_WR_BEST    = 4'd6;
    localparam logic [3:0] S_FSCAN      = 4'd7;
    localparam logic [3:0] S_WR_MERGE   = 4'd8;
    localparam logic [3:0] S_DN         = 4'd9;
    localparam logic [3:0] S_SHRINK     = 4'd10;
    localparam logic [3:0] S_STAT_BEGIN = 4'd11;
    localparam logic [3:0] S_STAT       = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       fwd_done;   // forward pass finished, pipeline drained
    logic       up_done;

    assign fwd_done = !i_stat.lt_count && !i_stat.vld;
    assign up_done  = !i_stat.gt_best && !i_stat.vld;
    assign o_busy   = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = bfa_pkg::CMD_NOP;
        unique case (r_state)
            S_INIT: begin
                o_cmd   = bfa_pkg::CMD_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = bfa_pkg::CMD_ACCEPT;
                    n_state = i_req_type ? S_FSCAN : S_ASCAN;
                end
            end
            S_ASCAN: begin
                o_cmd = bfa_pkg::CMD_SCAN_ALLOC;
                if (fwd_done) begin
                    if (!i_stat.found) begin
                        n_state = S_STAT_BEGIN;
                    end else if (i_stat.split && i_stat.full) begin
                        o_cmd   = bfa_pkg::CMD_MARK_FULL;
                        n_state = S_STAT_BEGIN;
                    end else if (i_stat.split) begin
                        n_state = S_UP_BEGIN;
                    end else begin
                        n_state = S_WR_BEST;
                    end
                end
            end
            S_UP_BEGIN: begin
                o_cmd   = bfa_pkg::CMD_UP_BEGIN;
                n_state = S_UP;
            end
            S_UP: begin
                o_cmd = bfa_pkg::CMD_UP_STEP;
                if (up_done) n_state = S_WR_SPLIT;
            end
            S_WR_SPLIT: begin
                o_cmd   = bfa_pkg::CMD_WR_SPLIT;
                n_state = S_WR_BEST;
            end
            S_WR_BEST: begin
                o_cmd   = bfa_pkg::CMD_WR_BEST;
                n_state = S_STAT_BEGIN;
            end
            S_FSCAN: begin
                o_cmd = bfa_pkg::CMD_SCAN_FREE;
                if (fwd_done) n_state = i_stat.found ? S_WR_MERGE : S_STAT_BEGIN;
            end
            S_WR_MERGE: begin
                o_cmd   = bfa_pkg::CMD_WR_MERGE;
                n_state = S_DN;
            end
            S_DN: begin
                o_cmd = bfa_pkg::CMD_DN_STEP;
                if (fwd_done) n_state = S_SHRINK;
            end
            S_SHRINK: begin
                o_cmd   = bfa_pkg::CMD_SHRINK;
                n_state = S_STAT_BEGIN;
            end
            S_STAT_BEGIN: begin
                o_cmd   = bfa_pkg::CMD_STAT_BEGIN;
                n_state = S_STAT;
            end
            S_STAT: begin
                if (fwd_done) begin
                    o_cmd   = bfa_pkg::CMD_FINISH;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = bfa_pkg::CMD_SCAN_STAT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/best_fit_allocator_top.sv]
// best_fit_allocator_top: best-fit allocator with coalescing, APB config port.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath (and bfa_ram below it).
`default_nettype none

// Best-fit allocator. The block table (start, size, free flag, owner id per
// entry) lives in a single-port-read RAM of MAX_BLOCKS words, so each request
// walks it one entry per cycle. Pulse start while busy is low; the request is
// taken on that edge. One result word per request comes back on the o_ ports
// with o_done high for exactly one cycle; there is no backpressure, so the
// receiver must take it then. busy drops in the cycle o_done rises, so a new
// start may be given in that same cycle. Each request makes a search pass over
// the table; an alloc that splits then shifts the entries above the best block
// up, and a free that finds its id writes the merged block and shifts the
// later entries down over it. Every request ends with a statistics pass. Each
// pass is paced by the single RAM read port. After reset busy stays high for one
// cycle while entry 0 is loaded. Writing the memory size register (byte
// address 0, bits [20:0]; 0 reads as 1, values above 2^20 clamp to 2^20)
// reloads the table as one free block; next id and both counters are kept.
// Write only when idle.
module best_fit_allocator_top #(
    parameter int MAX_BLOCKS = bfa_pkg::DEF_MAX_BLOCKS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // APB config port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // request
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_req_type,
    input  wire logic [bfa_pkg::SZ_W-1:0]  i_req_size,
    input  wire logic [bfa_pkg::ID_W-1:0]  i_free_id,
    // result
    output logic                           o_done,
    output logic      [1:0]                o_status,
    output logic      [bfa_pkg::ID_W-1:0]  o_alloc_id,
    output logic      [bfa_pkg::SZ_W-1:0]  o_alloc_start,
    output logic      [bfa_pkg::SZ_W-1:0]  o_used_total,
    output logic      [bfa_pkg::SZ_W-1:0]  o_free_total,
    output logic      [bfa_pkg::SZ_W-1:0]  o_largest_free,
    output logic      [bfa_pkg::ID_W-1:0]  o_request_count,
    output logic      [bfa_pkg::ID_W-1:0]  o_success_count
);

    bfa_pkg::t_cmd     cmd;
    bfa_pkg::t_dp_stat dp_stat;
    logic              cfg_wr;
    logic [bfa_pkg::SZ_W-1:0] mem_size;

    // only register 0 exists; paddr[1:0] is the byte lane and is ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - bfa_pkg::SZ_W){1'b0}}, mem_size};

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    bfa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (dp_stat),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_data      (pwdata[bfa_pkg::SZ_W-1:0]),
        .o_mem_size      (mem_size),
        .i_req_type      (i_req_type),
        .i_req_size      (i_req_size),
        .i_free_id       (i_free_id),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_alloc_id      (o_alloc_id),
        .o_alloc_start   (o_alloc_start),
        .o_used_total    (o_used_total),
        .o_free_total    (o_free_total),
        .o_largest_free  (o_largest_free),
        .o_request_count (o_request_count),
        .o_success_count (o_success_count)
    );

endmodule

`default_nettype wire

[rtl/bfa_checker.sv]
// bfa_checker: port-level assertions for best_fit_allocator_top, with bind.
// Depends on bfa_pkg.
`default_nettype none

module bfa_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_done,
    input wire logic [1:0]                o_status,
    input wire logic [bfa_pkg::ID_W-1:0]  o_alloc_id,
    input wire logic [bfa_pkg::SZ_W-1:0]  o_free_total,
    input wire logic [bfa_pkg::SZ_W-1:0]  o_largest_free
);

    // a result only follows a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without preceding busy");

    // the result strobe o_done drops again right after it rises
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != bfa_pkg::ST_OK) |-> (o_alloc_id == '0))
        else $error("failed request carries an id");

    a_largest_le_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_largest_free <= o_free_total))
        else $error("largest free block exceeds free total");

endmodule

bind best_fit_allocator_top bfa_checker u_bfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_alloc_id     (o_alloc_id),
    .o_free_total   (o_free_total),
    .o_largest_free (o_largest_free)
);

`default_nettype wire
